// ----- rtl/tws_pkg.sv -----
// Shared types and codes for the texture sampler with wrap and bilinear filtering.
// No dependencies; the front, back and top-level files refer to it by scoped names.
`default_nettype none

package tws_pkg;

	// Opcode of an input item
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_S     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_T     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER     = 3'd4;

	// Texel position width (sizes are held in 7-bit registers)
	localparam int POS_W = 7;
	// Row offset width, wide enough for any y * width + x
	localparam int ROW_W = 14;

	typedef struct packed {
		logic                op;
		logic [11:0]         texel_index;
		logic [31:0]         texel_value;
		logic signed [23:0]  u_coord;
		logic signed [23:0]  v_coord;
	} in_item_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} result_t;

	// Active configuration, sizes already clamped to 1..max
	typedef struct packed {
		logic [POS_W-1:0] width;
		logic [POS_W-1:0] height;
		logic             wrap_s;
		logic             wrap_t;
		logic             filter;
	} cfg_t;

	// Classified command handed from front to back
	typedef struct packed {
		logic             is_sample;
		logic             wr_ok;
		logic [11:0]      index;
		logic [31:0]      value;
		logic [POS_W-1:0] xi;
		logic [POS_W-1:0] xr;
		logic [POS_W-1:0] yi;
		logic [POS_W-1:0] yb;
	} cmd_t;

endpackage

`default_nettype wire

// ----- rtl/tws_front.sv -----
// Front end: accepts items, wraps and scales sample coordinates, classifies writes.
// Depends on tws_pkg.
`default_nettype none

module tws_front #(
	parameter int FRAC_BITS  = 16,
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire tws_pkg::in_item_t      item,
	input  wire tws_pkg::cfg_t          cfg,
	output logic                        push_s1,
	output tws_pkg::cmd_t               cmd_s1,
	output logic [2*FRAC_BITS-1:0]      wt_s1
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int PW    = FRAC_BITS + 8;

	// Wrap a coordinate into [0, ONE]
	function automatic logic [FRAC_BITS:0] wrap_fx(input logic signed [23:0] c,
			input logic mir);
		logic [24:0]        ext;
		logic [FRAC_BITS:0] m;
		ext = {c[23], c};
		m   = ext[FRAC_BITS:0];
		if (mir && m[FRAC_BITS]) begin
			wrap_fx = (~m) + {{FRAC_BITS{1'b0}}, 1'b1};
		end else if (mir) begin
			wrap_fx = m;
		end else begin
			wrap_fx = {1'b0, m[FRAC_BITS-1:0]};
		end
	endfunction

	logic [FRAC_BITS:0]          wu, wv;
	logic [PW-1:0]               fx, fy;
	logic [FRAC_BITS-1:0]        tx, ty;
	logic [tws_pkg::POS_W-1:0]   xi, yi;
	tws_pkg::cmd_t               cmd_d;

	// Wrap and scale by size minus one
	always_comb begin
		wu = wrap_fx(item.u_coord, cfg.wrap_s);
		wv = wrap_fx(item.v_coord, cfg.wrap_t);
		fx = PW'(wu) * PW'(cfg.width - 7'd1);
		fy = PW'(wv) * PW'(cfg.height - 7'd1);
		xi = fx[FRAC_BITS+6:FRAC_BITS];
		yi = fy[FRAC_BITS+6:FRAC_BITS];
		tx = cfg.filter ? fx[FRAC_BITS-1:0] : '0;
		ty = cfg.filter ? fy[FRAC_BITS-1:0] : '0;
		cmd_d.is_sample = (item.op == tws_pkg::OP_SAMPLE);
		cmd_d.wr_ok     = (32'(item.texel_index) < 32'(DEPTH));
		cmd_d.index     = item.texel_index;
		cmd_d.value     = item.texel_value;
		cmd_d.xi        = xi;
		cmd_d.yi        = yi;
		cmd_d.xr        = xi + tws_pkg::POS_W'(tx != '0);
		cmd_d.yb        = yi + tws_pkg::POS_W'(ty != '0);
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_s1 <= 1'b0;
		end else begin
			push_s1 <= accept;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
			wt_s1  <= {tx, ty};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tws_queue.sv -----
// Short FIFO that decouples the front end from the back end.
// Depends on nothing but its parameters.
`default_nettype none

module tws_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  nonempty,
	output logic                  full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign nonempty = (count_q != '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign do_pop   = pop && nonempty;
	assign do_push  = push && (!full || do_pop);
	assign dout     = slot_q[rd_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= din;
		end
	end

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || (pop && nonempty)))
		else $error("queue push lost while full");
	a_count_rng: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// ----- rtl/tws_back.sv -----
// Back end: texel addressing, dual-copy texel store, horizontal and vertical blend.
// Depends on tws_pkg.
`default_nettype none

module tws_back #(
	parameter int FRAC_BITS  = 16,
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 valid,
	input  wire tws_pkg::cmd_t        cmd,
	input  wire logic [2*FRAC_BITS-1:0] wt,
	input  wire tws_pkg::cfg_t        cfg,
	output logic                      pop,
	output tws_pkg::result_t          result,
	output logic                      result_valid
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = tws_pkg::ROW_W;

	// One channel: a + floor((b - a) * t / ONE)
	function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
			input logic [FRAC_BITS-1:0] t);
		logic signed [8:0]           d;
		logic signed [FRAC_BITS+9:0] p;
		logic signed [FRAC_BITS+9:0] s;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		p = d * $signed({1'b0, t});
		s = p >>> FRAC_BITS;
		lerp8 = a + s[7:0];
	endfunction

	function automatic logic [31:0] lerp4(input logic [31:0] a, input logic [31:0] b,
			input logic [FRAC_BITS-1:0] t);
		logic [31:0] r;
		for (int k = 0; k < 4; k++) begin
			r[8*k +: 8] = lerp8(a[8*k +: 8], b[8*k +: 8], t);
		end
		lerp4 = r;
	endfunction

	assign pop = valid;

	// Address stage
	logic [RW-1:0]        row_t, row_b;
	logic                 v_s2, smp_s2, we_s2;
	logic [AW-1:0]        a0_s2, a1_s2, a2_s2, a3_s2;
	logic [31:0]          val_s2;
	logic [FRAC_BITS-1:0] tx_s2, ty_s2;

	always_comb begin
		row_t = RW'(cmd.yi) * RW'(cfg.width);
		row_b = RW'(cmd.yb) * RW'(cfg.width);
	end

	always_ff @(posedge clk) begin
		a0_s2  <= cmd.is_sample ? AW'(row_t + RW'(cmd.xi)) : AW'(cmd.index);
		a1_s2  <= AW'(row_t + RW'(cmd.xr));
		a2_s2  <= AW'(row_b + RW'(cmd.xi));
		a3_s2  <= AW'(row_b + RW'(cmd.xr));
		val_s2 <= cmd.value;
		tx_s2  <= wt[2*FRAC_BITS-1:FRAC_BITS];
		ty_s2  <= wt[FRAC_BITS-1:0];
	end

	// Texel store, two copies for four reads per cycle
	logic [31:0]          mem_a [DEPTH];
	logic [31:0]          mem_b [DEPTH];
	logic [31:0]          rd0_s3, rd1_s3, rd2_s3, rd3_s3;
	logic [FRAC_BITS-1:0] tx_s3, ty_s3;
	logic                 v_s3, smp_s3;

	always_ff @(posedge clk) begin
		if (we_s2) begin
			mem_a[a0_s2] <= val_s2;
			mem_b[a0_s2] <= val_s2;
		end
		rd0_s3 <= mem_a[a0_s2];
		rd1_s3 <= mem_a[a1_s2];
		rd2_s3 <= mem_b[a2_s2];
		rd3_s3 <= mem_b[a3_s2];
		tx_s3  <= tx_s2;
		ty_s3  <= ty_s2;
	end

	// Horizontal blend
	logic [31:0]          top_s4, bot_s4;
	logic [FRAC_BITS-1:0] ty_s4;
	logic                 v_s4, smp_s4;

	always_ff @(posedge clk) begin
		top_s4 <= lerp4(rd0_s3, rd1_s3, tx_s3);
		bot_s4 <= lerp4(rd2_s3, rd3_s3, tx_s3);
		ty_s4  <= ty_s3;
	end

	// Vertical blend into the output register
	always_ff @(posedge clk) begin
		result <= tws_pkg::result_t'(lerp4(top_s4, bot_s4, ty_s4));
	end

	// Control flow through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2         <= 1'b0;
			smp_s2       <= 1'b0;
			we_s2        <= 1'b0;
			v_s3         <= 1'b0;
			smp_s3       <= 1'b0;
			v_s4         <= 1'b0;
			smp_s4       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			v_s2         <= valid;
			smp_s2       <= valid && cmd.is_sample;
			we_s2        <= valid && !cmd.is_sample && cmd.wr_ok;
			v_s3         <= v_s2;
			smp_s3       <= smp_s2;
			v_s4         <= v_s3;
			smp_s4       <= smp_s3;
			result_valid <= v_s4 && smp_s4;
		end
	end

	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid == $past(v_s4 && smp_s4))
		else $error("result strobe not tied to a sample");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(we_s2 && smp_s2))
		else $error("write and sample in the same slot");
	a_smp_v: assert property (@(posedge clk) disable iff (!arst_n)
		smp_s3 |-> v_s3)
		else $error("sample flag without valid");

endmodule

`default_nettype wire

// ----- rtl/texture_sampler_wrap_bilinear_unit.sv -----
// Top level of the texture sampler: configuration registers, front, queue, back.
// Depends on tws_pkg, tws_front, tws_queue and tws_back.
//
// Use: drive in_item and raise start; the item is taken at a clock edge with
// start high and busy low. A write item stores texel_value at texel_index and
// gives no result. A sample item wraps u/v (repeat or mirrored repeat), scales
// by size minus one and returns one RGBA8 texel, nearest or bilinear.
// Results show on result for one cycle with result_valid high; the receiver
// cannot hold them off.
// Throughput: one item per clock. The back end takes an entry from the queue
// in every cycle that the queue holds one, so busy stays low in operation.
// Path: a sample is registered in turn by the front register, the queue, the
// address stage, the store read and the horizontal blend, and the vertical
// blend loads the output register that drives result.
// Configuration: cfg_we, cfg_index, cfg_data write one register per clock; write
// only while no item is in flight.
// Reset: registers return to width 1, height 1, repeat, nearest; the texel
// store is not cleared and must be written before it is sampled.
`default_nettype none

module texture_sampler_wrap_bilinear_unit #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire tws_pkg::in_item_t                 in_item,
	output tws_pkg::result_t                       result,
	output logic                                   result_valid,
	input  wire logic                              cfg_we,
	input  wire logic [tws_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tws_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int QW = $bits(tws_pkg::cmd_t) + 2 * FRAC_BITS;

	logic [6:0]    tex_width_q, tex_height_q;
	logic          wrap_s_q, wrap_t_q, filter_q;
	tws_pkg::cfg_t cfg;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= 7'd1;
			tex_height_q <= 7'd1;
			wrap_s_q     <= 1'b0;
			wrap_t_q     <= 1'b0;
			filter_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tws_pkg::CFG_TEX_WIDTH:  tex_width_q  <= cfg_data;
				tws_pkg::CFG_TEX_HEIGHT: tex_height_q <= cfg_data;
				tws_pkg::CFG_WRAP_S:     wrap_s_q     <= cfg_data[0];
				tws_pkg::CFG_WRAP_T:     wrap_t_q     <= cfg_data[0];
				tws_pkg::CFG_FILTER:     filter_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp sizes to 1..max
	always_comb begin
		if (tex_width_q == 7'd0) begin
			cfg.width = 7'd1;
		end else if (32'(tex_width_q) > 32'(MAX_WIDTH)) begin
			cfg.width = 7'(MAX_WIDTH);
		end else begin
			cfg.width = tex_width_q;
		end
		if (tex_height_q == 7'd0) begin
			cfg.height = 7'd1;
		end else if (32'(tex_height_q) > 32'(MAX_HEIGHT)) begin
			cfg.height = 7'(MAX_HEIGHT);
		end else begin
			cfg.height = tex_height_q;
		end
		cfg.wrap_s = wrap_s_q;
		cfg.wrap_t = wrap_t_q;
		cfg.filter = filter_q;
	end

	logic                   accept;
	logic                   push_s1;
	tws_pkg::cmd_t          cmd_s1, q_cmd;
	logic [2*FRAC_BITS-1:0] wt_s1, q_wt;
	logic                   q_nonempty, q_full, q_pop;

	assign busy   = q_full;
	assign accept = start && !busy;

	tws_front #(
		.FRAC_BITS(FRAC_BITS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .item(in_item), .cfg(cfg),
		.push_s1(push_s1), .cmd_s1(cmd_s1), .wt_s1(wt_s1)
	);

	tws_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push_s1), .din({cmd_s1, wt_s1}),
		.pop(q_pop), .dout({q_cmd, q_wt}), .nonempty(q_nonempty), .full(q_full)
	);

	tws_back #(
		.FRAC_BITS(FRAC_BITS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk(clk), .arst_n(arst_n), .valid(q_nonempty), .cmd(q_cmd), .wt(q_wt),
		.cfg(cfg), .pop(q_pop), .result(result), .result_valid(result_valid)
	);

endmodule

`default_nettype wire
